FILE: rtl/positional_array_list_assert.svh
// ----------------------------------------------------------------------------
// positional_array_list assertion macros
// short forms for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// condition seen now implies a consequence in the same cycle
`define PAL_ASSERT_NOW(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// condition seen now implies a consequence in the next cycle
`define PAL_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// shared codes, defaults and types of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 16;
    localparam int ACTION_W        = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_REM_HEAD = 3'd3,
        ACT_REM_TAIL = 3'd4,
        ACT_REM_POS  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

FILE: rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// one list slot: holds an entry and shifts it with its neighbors
// ----------------------------------------------------------------------------
module pal_cell
    import pal_pkg::*;
#(
    parameter int EW  = ENTRY_WIDTH_DEF,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  cell_cmd_t     cmd,
    input  logic [CW-1:0] pos,
    input  logic [EW-1:0] ins_value,
    input  logic [EW-1:0] left,
    input  logic [EW-1:0] right,
    output logic [EW-1:0] q,
    output logic [EW-1:0] tap
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [EW-1:0] data_reg;
    logic [EW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (MY_IDX > pos) begin
                data_next = left;
            end else if (MY_IDX == pos) begin
                data_next = ins_value;
            end
        end else if (cmd.rem && (MY_IDX >= pos)) begin
            data_next = right;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q   = data_reg;
    // only the addressed slot drives the read-out bus
    assign tap = (MY_IDX == pos) ? data_reg : '0;

endmodule

FILE: rtl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// decodes the action, checks full, empty and range, keeps the entry count
// ----------------------------------------------------------------------------
module pal_ctrl
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [ACTION_W-1:0] action,
    input  logic [CW-1:0]       pos_in,
    output cell_cmd_t           cmd,
    output logic [CW-1:0]       pos_eff,
    output status_t             status,
    output logic [CW-1:0]       cnt,
    output logic [CW-1:0]       cnt_after
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    always_comb begin
        cmd.ins  = 1'b0;
        cmd.rem  = 1'b0;
        pos_eff  = '0;
        status   = ST_OK;
        case (action)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
                if (action == ACT_INS_HEAD) begin
                    pos_eff = '0;
                end else if (action == ACT_INS_TAIL) begin
                    pos_eff = cnt_reg;
                end else begin
                    pos_eff = pos_in;
                end
                if (cnt_reg >= FULL_CNT) begin
                    status = ST_FULL;
                end else if (pos_eff > cnt_reg) begin
                    status = ST_RANGE;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
                if (action == ACT_REM_HEAD) begin
                    pos_eff = '0;
                end else if (action == ACT_REM_TAIL) begin
                    pos_eff = cnt_reg - CW'(1);
                end else begin
                    pos_eff = pos_in;
                end
                if (cnt_reg == '0) begin
                    status = ST_EMPTY;
                end else if (pos_eff >= cnt_reg) begin
                    status = ST_RANGE;
                end else begin
                    cmd.rem = 1'b1;
                end
            end
            default: begin
                // unused codes do nothing
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        cnt_after = cnt_reg;
        if (cmd.ins) begin
            cnt_after = cnt_reg + CW'(1);
        end else if (cmd.rem) begin
            cnt_after = cnt_reg - CW'(1);
        end
        cnt_next = fire ? cnt_after : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

FILE: rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of up to DEPTH entries with insert and remove at any position
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)            | tuser
//  s_      | in  | position, value               | action
//  m_      | out | removed_value, count          | status
//
//  one word per cycle: a whole-row shift of the cell chain does each action
//  in the cycle it is accepted, and the result lands in the output register
//  s_tready is low only while a result waits and m_tready is low
//  reset clears the entry count and the output valid; slots are not cleared
//  a stalled result holds, the list does not change until it is taken
// ----------------------------------------------------------------------------
`include "positional_array_list_assert.svh"

module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int S_W        = ((CW + ENTRY_WIDTH + 7) / 8) * 8,
    localparam int M_W        = ((ENTRY_WIDTH + CW + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_W-1:0]      s_tdata,   // position, value
    input  logic [ACTION_W-1:0] s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_W-1:0]      m_tdata,   // removed_value, count
    output logic [STATUS_W-1:0] m_tuser    // status
);

    logic                   fire;
    logic [CW-1:0]          pos_in;
    logic [ENTRY_WIDTH-1:0] ins_value;
    cell_cmd_t              cmd;
    logic [CW-1:0]          pos_eff;
    status_t                status;
    logic [CW-1:0]          cnt;
    logic [CW-1:0]          cnt_after;
    cell_cmd_t              cell_cmd;

    logic [ENTRY_WIDTH-1:0] q   [DEPTH];
    logic [ENTRY_WIDTH-1:0] tap [DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_value;

    logic                   m_valid_reg;
    logic [M_W-1:0]         m_data_reg;
    logic [STATUS_W-1:0]    m_status_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign pos_in    = s_tdata[CW-1:0];
    assign ins_value = s_tdata[CW+ENTRY_WIDTH-1:CW];

    pal_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .action    (s_tuser),
        .pos_in    (pos_in),
        .cmd       (cmd),
        .pos_eff   (pos_eff),
        .status    (status),
        .cnt       (cnt),
        .cnt_after (cnt_after)
    );

    // cells only move on an accepted word
    assign cell_cmd.ins = cmd.ins && fire;
    assign cell_cmd.rem = cmd.rem && fire;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] left_n;
        logic [ENTRY_WIDTH-1:0] right_n;
        if (i == 0) begin : g_first
            assign left_n = ins_value;
        end else begin : g_mid_l
            assign left_n = q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_n = q[i];
        end else begin : g_mid_r
            assign right_n = q[i+1];
        end
        pal_cell #(
            .EW  (ENTRY_WIDTH),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cell_cmd),
            .pos       (pos_eff),
            .ins_value (ins_value),
            .left      (left_n),
            .right     (right_n),
            .q         (q[i]),
            .tap       (tap[i])
        );
    end

    // one-hot taps, so an or over the row picks the addressed slot
    always_comb begin
        rd_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_value = rd_value | tap[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (fire) begin
            m_data_reg   <= M_W'({cnt_after, (cmd.rem ? rd_value : {ENTRY_WIDTH{1'b0}})});
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `PAL_ASSERT_NEXT(a_ins_grows, aclk, aresetn, fire && cmd.ins,
        cnt == $past(cnt) + CW'(1), "insert did not grow the count")
    `PAL_ASSERT_NEXT(a_rem_shrinks, aclk, aresetn, fire && cmd.rem,
        cnt == $past(cnt) - CW'(1), "remove did not shrink the count")
    `PAL_ASSERT_NEXT(a_fail_holds, aclk, aresetn, fire && !cmd.ins && !cmd.rem,
        $stable(cnt) && (m_tdata[ENTRY_WIDTH-1:0] == '0), "failed action changed state")
    `PAL_ASSERT_NOW(a_cnt_bound, aclk, aresetn, m_tvalid,
        m_tdata[ENTRY_WIDTH+CW-1:ENTRY_WIDTH] <= CW'(DEPTH), "count beyond depth")

endmodule
